// ===== hdl/grbls_pkg.sv =====
package grbls_pkg;

   // store geometry
   localparam int ROWS            = 64;
   localparam int LINE_BYTES      = 48;
   localparam int MAX_GLYPH_WIDTH = 32;

   localparam int LINE_DOTS     = LINE_BYTES * 8;
   localparam int WORDS_PER_ROW = (LINE_BYTES + 3) / 4;
   localparam int MEM_WORDS     = ROWS * WORDS_PER_ROW;
   localparam int ROW_W         = $clog2(ROWS);
   localparam int WORD_W        = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
   localparam int ADDR_W        = $clog2(MEM_WORDS);

   // input field widths
   localparam int KIND_W   = 2;
   localparam int ROW_F_W  = 6;
   localparam int START_W  = 9;
   localparam int GW_W     = 6;
   localparam int PIX_W    = 32;

   // output field widths
   localparam int DWORD_W  = 32;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 9;
   localparam int POP_W    = 6;

   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = KIND_W;
   localparam int RSP_DATA_W = 48;

   // compare widths wide enough for start+width and row+rows
   localparam int DOT_W    = ($clog2(LINE_DOTS + 1) > START_W + 1) ?
                             $clog2(LINE_DOTS + 1) : START_W + 1;
   localparam int ROWEND_W = ($clog2(ROWS + 1) > ROW_F_W + 2) ?
                             $clog2(ROWS + 1) : ROW_F_W + 2;

   // command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // heat dot count masks
   localparam logic [31:0] DOT_MASK_A = 32'h4924_9249;
   localparam logic [31:0] DOT_MASK_B = 32'hC71C_71C7;

   typedef enum logic [KIND_W-1:0] {
      KIND_BLIT  = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW,
      ST_INIT,
      ST_RD,
      ST_WR,
      ST_RQ,
      ST_EMIT
   } state_type;

   // one decoded command, byte positions 0..7 span two store words
   typedef struct packed {
      kind_type          op;
      logic [ROW_W-1:0]  row;
      logic              row_ok;
      logic              two_rows;
      logic [WORD_W-1:0] word;
      logic [63:0]       data;
      logic [7:0]        be;
      logic [7:0]        orm;
   } cmd_type;

   function automatic logic [POP_W-1:0] dots_in_word(input logic [31:0] word);
      logic [31:0] n;
      n = word;
      n = n - ((n & (DOT_MASK_A << 1)) >> 1);
      n = n + (n & (DOT_MASK_A >> 1));
      n = n + (n >> 3);
      n = n & DOT_MASK_B;
      n = n + (n >> 6);
      n = n + (n >> 12);
      n = n + (n >> 24);
      return n[POP_W-1:0];
   endfunction

endpackage

// ===== hdl/grbls_front.sv =====
module grbls_front (
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [grbls_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [grbls_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic                                 queue_full,
   output logic                                 push,
   output grbls_pkg::cmd_type                   push_data
);

   grbls_pkg::kind_type               kind;
   logic [grbls_pkg::ROW_F_W-1:0]     row_f;
   logic [grbls_pkg::START_W-1:0]     start_f;
   logic [grbls_pkg::GW_W-1:0]        gw_f;
   logic [grbls_pkg::PIX_W-1:0]       pix_f;
   logic                              inv_f;
   logic                              dbl_f;

   logic                              width_ok;
   logic                              span_ok;
   logic                              rows_ok;
   logic                              read_ok;
   logic [grbls_pkg::ROW_F_W:0]       r0;
   logic [grbls_pkg::ROWEND_W-1:0]    row_end;
   logic [2:0]                        nb;
   logic [2:0]                        rem;
   logic [7:0]                        pad_mask;
   logic [3:0][7:0]                   g;
   logic [2:0]                        s;
   logic                              aligned;
   logic [39:0]                       seq;
   logic [2:0]                        nbytes;
   logic [5:0]                        b;
   logic [1:0]                        o;
   logic [4:0]                        be5;
   logic                              keep;

   assign kind    = grbls_pkg::kind_type'(req_tuser);
   assign row_f   = req_tdata[5:0];
   assign start_f = req_tdata[14:6];
   assign gw_f    = req_tdata[20:15];
   assign pix_f   = req_tdata[52:21];
   assign inv_f   = req_tdata[53];
   assign dbl_f   = req_tdata[54];

   // blit checks
   assign width_ok = (gw_f != '0) && ({1'b0, gw_f} <= 7'd32)
                   && ({1'b0, gw_f} <= 7'(grbls_pkg::MAX_GLYPH_WIDTH));
   assign span_ok  = (grbls_pkg::DOT_W'(start_f) + grbls_pkg::DOT_W'(gw_f))
                   <= grbls_pkg::DOT_W'(grbls_pkg::LINE_DOTS);
   assign r0       = dbl_f ? {row_f, 1'b0} : {1'b0, row_f};
   assign row_end  = grbls_pkg::ROWEND_W'(r0)
                   + (dbl_f ? grbls_pkg::ROWEND_W'(2) : grbls_pkg::ROWEND_W'(1));
   assign rows_ok  = row_end <= grbls_pkg::ROWEND_W'(grbls_pkg::ROWS);
   assign read_ok  = grbls_pkg::ROWEND_W'(row_f) < grbls_pkg::ROWEND_W'(grbls_pkg::ROWS);

   assign nb       = 3'((7'(gw_f) + 7'd7) >> 3);
   assign rem      = gw_f[2:0];
   assign pad_mask = 8'(8'hFF << (4'd8 - 4'(rem)));

   // glyph bytes, inverted and trimmed, zero beyond the used bytes
   always_comb begin
      logic [7:0] gbyte;
      gbyte = 8'h00;
      for (int i = 0; i < 4; i++) begin
         gbyte = pix_f[31-8*i -: 8];
         if (3'(i) < nb) begin
            if (inv_f) begin
               gbyte = ~gbyte;
            end
            if (inv_f && (rem != 3'd0) && (3'(i) == nb - 3'd1)) begin
               gbyte = gbyte & pad_mask;
            end
         end else begin
            gbyte = 8'h00;
         end
         g[i] = gbyte;
      end
   end

   assign s       = start_f[2:0];
   assign aligned = (s == 3'd0);
   assign seq     = {g[0], g[1], g[2], g[3], 8'h00} >> s;
   assign nbytes  = aligned ? nb : nb + 3'd1;
   assign b       = start_f[8:3];
   assign o       = start_f[4:3];

   // bytes past the line end are dropped
   always_comb begin
      for (int j = 0; j < 5; j++) begin
         be5[j] = (3'(j) < nbytes)
                && ((grbls_pkg::DOT_W'(b) + grbls_pkg::DOT_W'(j))
                    < grbls_pkg::DOT_W'(grbls_pkg::LINE_BYTES));
      end
   end

   always_comb begin
      int j;
      j = 0;
      push_data          = '0;
      push_data.op       = kind;
      push_data.two_rows = dbl_f;
      push_data.word     = grbls_pkg::WORD_W'(start_f >> 5);
      push_data.row_ok   = read_ok;
      if (kind == grbls_pkg::KIND_BLIT) begin
         push_data.row = grbls_pkg::ROW_W'(r0);
      end else begin
         push_data.row = grbls_pkg::ROW_W'(row_f);
      end
      for (int p = 0; p < 8; p++) begin
         j = p - int'(o);
         if ((j >= 0) && (j < 5)) begin
            push_data.data[63-8*p -: 8] = seq[39-8*j -: 8];
            push_data.be[p]             = be5[j];
            push_data.orm[p]            = (j == 0) && !aligned;
         end
      end
   end

   always_comb begin
      unique case (kind)
         grbls_pkg::KIND_BLIT:  keep = width_ok && span_ok && rows_ok;
         grbls_pkg::KIND_CLEAR: keep = 1'b1;
         grbls_pkg::KIND_READ:  keep = 1'b1;
         default:               keep = 1'b0;
      endcase
   end

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full && keep;

endmodule

// ===== hdl/grbls_fifo.sv =====
module grbls_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  grbls_pkg::cmd_type push_data,
   output logic               full,
   input  logic               pop,
   output grbls_pkg::cmd_type pop_data,
   output logic               empty
);

   grbls_pkg::cmd_type               entries_ff [grbls_pkg::QUEUE_DEPTH];
   logic [grbls_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [grbls_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [grbls_pkg::QPTR_W:0]       count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full     = count_ff == (grbls_pkg::QPTR_W + 1)'(grbls_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == grbls_pkg::QPTR_W'(grbls_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == grbls_pkg::QPTR_W'(grbls_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/grbls_back.sv =====
module grbls_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   input  grbls_pkg::cmd_type                cmd,
   output logic                              cmd_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [grbls_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast
);

   grbls_pkg::state_type              state_ff, state_in;
   grbls_pkg::cmd_type                cmd_ff, cmd_in;
   logic                              row_sel_ff, row_sel_in;
   logic                              word_sel_ff, word_sel_in;
   logic [grbls_pkg::WORD_W-1:0]      cnt_ff, cnt_in;
   logic [grbls_pkg::ROWS-1:0]        valid_ff, valid_in;
   logic [grbls_pkg::COUNT_W-1:0]     total_ff, total_in;
   logic [31:0]                       rdata_ff;

   logic                              rsp_valid_ff;
   logic [grbls_pkg::DWORD_W-1:0]     rsp_word_ff;
   logic [grbls_pkg::INDEX_W-1:0]     rsp_index_ff;
   logic [grbls_pkg::COUNT_W-1:0]     rsp_count_ff;
   logic                              rsp_last_ff;

   logic [31:0]                       line_store_mem [grbls_pkg::MEM_WORDS];
   logic                              mem_we;
   logic [grbls_pkg::ADDR_W-1:0]      mem_waddr;
   logic [31:0]                       mem_wdata;
   logic                              mem_re;
   logic [grbls_pkg::ADDR_W-1:0]      mem_raddr;

   logic [grbls_pkg::ROW_W-1:0]       cur_row;
   logic [grbls_pkg::WORD_W-1:0]      blit_word;
   logic                              cnt_last;
   logic                              hi_more;
   logic                              emit_load;
   logic [31:0]                       emit_word;
   logic [grbls_pkg::COUNT_W-1:0]     emit_sum;

   function automatic logic [grbls_pkg::ADDR_W-1:0] addr_of(
      input logic [grbls_pkg::ROW_W-1:0]  r,
      input logic [grbls_pkg::WORD_W-1:0] w
   );
      return grbls_pkg::ADDR_W'(r) * grbls_pkg::ADDR_W'(grbls_pkg::WORDS_PER_ROW)
           + grbls_pkg::ADDR_W'(w);
   endfunction

   assign cur_row   = cmd_ff.row + grbls_pkg::ROW_W'(row_sel_ff);
   assign blit_word = cmd_ff.word + grbls_pkg::WORD_W'(word_sel_ff);
   assign cnt_last  = cnt_ff == grbls_pkg::WORD_W'(grbls_pkg::WORDS_PER_ROW - 1);
   assign hi_more   = !word_sel_ff && (cmd_ff.be[7:4] != 4'd0);
   assign emit_load = (state_ff == grbls_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign emit_word = (cmd_ff.row_ok && valid_ff[cmd_ff.row]) ? rdata_ff : 32'd0;
   assign emit_sum  = total_ff + grbls_pkg::COUNT_W'(grbls_pkg::dots_in_word(emit_word));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         grbls_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  grbls_pkg::KIND_BLIT: state_in = grbls_pkg::ST_ROW;
                  grbls_pkg::KIND_READ: state_in = grbls_pkg::ST_RQ;
                  default:              state_in = grbls_pkg::ST_IDLE;
               endcase
            end
         end
         grbls_pkg::ST_ROW: begin
            state_in = valid_ff[cur_row] ? grbls_pkg::ST_RD : grbls_pkg::ST_INIT;
         end
         grbls_pkg::ST_INIT: begin
            if (cnt_last) begin
               state_in = grbls_pkg::ST_RD;
            end
         end
         grbls_pkg::ST_RD: begin
            state_in = grbls_pkg::ST_WR;
         end
         grbls_pkg::ST_WR: begin
            priority if (hi_more) begin
               state_in = grbls_pkg::ST_RD;
            end else if (cmd_ff.two_rows && !row_sel_ff) begin
               state_in = grbls_pkg::ST_ROW;
            end else begin
               state_in = grbls_pkg::ST_IDLE;
            end
         end
         grbls_pkg::ST_RQ: begin
            state_in = grbls_pkg::ST_EMIT;
         end
         grbls_pkg::ST_EMIT: begin
            if (emit_load) begin
               state_in = cnt_last ? grbls_pkg::ST_IDLE : grbls_pkg::ST_RQ;
            end
         end
         default: state_in = grbls_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      logic [7:0] old_byte;
      logic [7:0] new_byte;
      int         p;
      old_byte    = 8'h00;
      new_byte    = 8'h00;
      p           = 0;
      cmd_pop     = 1'b0;
      cmd_in      = cmd_ff;
      row_sel_in  = row_sel_ff;
      word_sel_in = word_sel_ff;
      cnt_in      = cnt_ff;
      valid_in    = valid_ff;
      total_in    = total_ff;
      mem_we      = 1'b0;
      mem_waddr   = addr_of(cur_row, cnt_ff);
      mem_wdata   = 32'd0;
      mem_re      = 1'b0;
      mem_raddr   = addr_of(cur_row, blit_word);
      unique case (state_ff)
         grbls_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               cmd_in      = cmd;
               row_sel_in  = 1'b0;
               word_sel_in = 1'b0;
               cnt_in      = '0;
               total_in    = '0;
               if (cmd.op == grbls_pkg::KIND_CLEAR) begin
                  valid_in = '0;
               end
            end
         end
         grbls_pkg::ST_ROW: begin
            cnt_in = '0;
         end
         grbls_pkg::ST_INIT: begin
            // zero the row once before its first write
            mem_we = 1'b1;
            if (cnt_last) begin
               valid_in[cur_row] = 1'b1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         grbls_pkg::ST_RD: begin
            mem_re = 1'b1;
         end
         grbls_pkg::ST_WR: begin
            mem_we    = 1'b1;
            mem_waddr = addr_of(cur_row, blit_word);
            for (int q = 0; q < 4; q++) begin
               p        = word_sel_ff ? q + 4 : q;
               old_byte = rdata_ff[31-8*q -: 8];
               new_byte = cmd_ff.data[63-8*p -: 8];
               if (!cmd_ff.be[p]) begin
                  new_byte = old_byte;
               end else if (cmd_ff.orm[p]) begin
                  new_byte = new_byte | old_byte;
               end
               mem_wdata[31-8*q -: 8] = new_byte;
            end
            priority if (hi_more) begin
               word_sel_in = 1'b1;
            end else if (cmd_ff.two_rows && !row_sel_ff) begin
               row_sel_in  = 1'b1;
               word_sel_in = 1'b0;
            end
         end
         grbls_pkg::ST_RQ: begin
            mem_re    = 1'b1;
            mem_raddr = addr_of(cmd_ff.row, cnt_ff);
         end
         grbls_pkg::ST_EMIT: begin
            if (emit_load) begin
               total_in = emit_sum;
               if (!cnt_last) begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= grbls_pkg::ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      row_sel_ff  <= row_sel_in;
      word_sel_ff <= word_sel_in;
      cnt_ff      <= cnt_in;
      total_ff    <= total_in;
      if (emit_load) begin
         rsp_word_ff  <= emit_word;
         rsp_index_ff <= grbls_pkg::INDEX_W'(cnt_ff);
         rsp_count_ff <= cnt_last ? emit_sum : '0;
         rsp_last_ff  <= cnt_last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= line_store_mem[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_index_ff, rsp_word_ff};

endmodule

// ===== hdl/glyph_row_blit_line_store_top.sv =====
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata: item fields, tuser: kind
// rsp      out  rsp_tvalid/rsp_tready  tdata: word fields, tlast: final word of a row
//
// blit: each word of the span is read, then merged and written back to the store;
// a double-height blit repeats this for its second row, and a row first touched
// after reset or a clear is zeroed word by word before its first write
// a read is a dispatch, then a read and an emit for each of the 12 words of the row
// reset and clear drop the per-row valid bits, no clearing pass
// the front takes beats into a 4-entry queue while the back stalls, until it fills
module glyph_row_blit_line_store_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // row[5:0], dot_col[14:6], glyph_width[20:15], pixels[52:21],
   // invert[53], double_height[54], zero fill[55]
   input  logic [grbls_pkg::REQ_DATA_W-1:0]     req_tdata,
   // kind[1:0]
   input  logic [grbls_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // data_word[31:0], word_index[35:32], dot_count[44:36], zero fill[47:45]
   output logic [grbls_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast
);

   logic               push;
   grbls_pkg::cmd_type push_data;
   logic               queue_full;
   logic               queue_empty;
   logic               cmd_pop;
   grbls_pkg::cmd_type cmd_head;

   // front: checks the item, drops bad blits and unused kinds,
   // and works out the byte window of a blit
   grbls_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // decoded commands waiting for the back end
   grbls_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head),
      .empty     (queue_empty)
   );

   // back: line store, read-modify-write of blits, row readout
   // into an output register
   grbls_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (!queue_empty),
      .cmd        (cmd_head),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== verif/tb_glyph_row_blit_line_store_top.sv =====
module tb_glyph_row_blit_line_store_top;
   import grbls_pkg::*;

   // run shape
   localparam int RANDOM_ITEMS = 150;
   localparam int HOLD_AFTER   = 70;    // accepted items before the long receiver hold-off
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 64;    // run-on after the last read, for blits still in flight
   localparam int STALL_LIMIT  = 2000;  // cycles without any beat on either side

   // tuser code with no operation behind it
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ROW_F_W-1:0] row;
      logic [START_W-1:0] dot_col;
      logic [GW_W-1:0]    glyph_width;
      logic [PIX_W-1:0]   pixels;
      logic               invert;
      logic               double_height;
   } glyph_item_type;

   typedef struct {
      logic [DWORD_W-1:0] data_word;
      logic [INDEX_W-1:0] word_index;
      logic [COUNT_W-1:0] dot_count;
      logic               last;
   } row_word_type;

   // receiver stall patterns
   typedef enum {RX_STEADY, RX_CHOPPY, RX_SPARSE} rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // row[5:0], dot_col[14:6], glyph_width[20:15], pixels[52:21],
   // invert[53], double_height[54], zero fill[55]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // kind[1:0]
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // data_word[31:0], word_index[35:32], dot_count[44:36], zero fill[47:45]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   glyph_item_type pending_items[$];
   row_word_type   expected_words[$];
   logic [7:0]  line_image [ROWS][LINE_BYTES];
   int          items_accepted = 0;
   int          total_items = 0;
   int          mismatches = 0;
   int          idle_cycles = 0;

   glyph_row_blit_line_store_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------
   // line store image kept by the checker
   // ---------------------------------------------------------------

   task automatic wipe_line_image();
      foreach (line_image[r, c]) line_image[r][c] = 8'h00;
   endtask

   // place one glyph row, once or twice for double height
   task automatic blit_glyph_row(input glyph_item_type it);
      int         nb, rem, r0, nrows, b, s, idx, i, k;
      logic [7:0] g [4];
      logic [7:0] v;
      if (it.glyph_width == 0 || it.glyph_width > 32 || it.glyph_width > MAX_GLYPH_WIDTH)
         return;
      // glyph would run past the right edge of the line
      if (int'(it.dot_col) + int'(it.glyph_width) > LINE_DOTS) return;
      nrows = it.double_height ? 2 : 1;
      r0    = it.double_height ? 2 * int'(it.row) : int'(it.row);
      if (r0 + nrows > ROWS) return;
      nb  = (int'(it.glyph_width) + 7) / 8;
      rem = int'(it.glyph_width) % 8;
      for (i = 0; i < 4; i++) g[i] = it.pixels[31 - 8*i -: 8];
      if (it.invert) begin
         for (i = 0; i < nb; i++) g[i] = ~g[i];
         // dots beyond the glyph width stay clear after inversion
         if (rem != 0) g[nb-1] = g[nb-1] & (8'hFF << (8 - rem));
      end
      b = int'(it.dot_col) / 8;
      s = int'(it.dot_col) % 8;
      for (k = 0; k < nrows; k++) begin
         if (s == 0) begin
            for (i = 0; i < nb; i++)
               if (b + i < LINE_BYTES) line_image[r0+k][b+i] = g[i];
         end else begin
            // first byte keeps its left dots, the rest is overwritten
            if (b < LINE_BYTES) line_image[r0+k][b] = line_image[r0+k][b] | (g[0] >> s);
            for (i = 0; i < nb; i++) begin
               idx = b + i + 1;
               v   = g[i] << (8 - s);
               if (i + 1 < nb) v = v | (g[i+1] >> s);
               // spill byte past the line end is dropped
               if (idx < LINE_BYTES) line_image[r0+k][idx] = v;
            end
         end
      end
   endtask

   // words of one row, heat dot total on the last one
   task automatic read_out_row(input logic [ROW_F_W-1:0] row);
      logic [31:0] w;
      int          total, k, j;
      row_word_type e;
      total = 0;
      for (k = 0; k < WORDS_PER_ROW; k++) begin
         w = '0;
         for (j = 0; j < 4; j++)
            if (row < ROWS && 4*k + j < LINE_BYTES) w[31 - 8*j -: 8] = line_image[row][4*k + j];
         total += $countones(w);
         e.data_word  = w;
         e.word_index = k[INDEX_W-1:0];
         e.last       = (k == WORDS_PER_ROW - 1);
         e.dot_count  = e.last ? total[COUNT_W-1:0] : '0;
         expected_words.push_back(e);
      end
   endtask

   function automatic void queue_item(logic [KIND_W-1:0] kind, int row, int dot_col,
                                      int width, logic [PIX_W-1:0] pixels, int invert,
                                      int dbl);
      glyph_item_type it;
      it.kind          = kind;
      it.row           = ROW_F_W'(row);
      it.dot_col       = START_W'(dot_col);
      it.glyph_width   = GW_W'(width);
      it.pixels        = pixels;
      it.invert        = 1'(invert);
      it.double_height = 1'(dbl);
      pending_items.push_back(it);
   endfunction

   // ---------------------------------------------------------------
   // request driver: bursts of beats with random gaps
   // ---------------------------------------------------------------

   always @(posedge clock) begin : req_driver
      int          burst_left;
      int          gap_left;
      logic        offer;
      glyph_item_type it;
      if (reset) begin
         burst_left = 8;
         gap_left   = 0;
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            void'(pending_items.pop_front());
            items_accepted <= items_accepted + 1;
            offer = 1'b0;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 16);
               // a third of the bursts follow straight on
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
         end
         if (!offer) begin
            if (gap_left > 0) gap_left--;
            else if (pending_items.size() > 0) offer = 1'b1;
         end
         req_tvalid <= offer;
         if (offer) begin
            it = pending_items[0];
            req_tdata <= {1'b0, it.double_height, it.invert, it.pixels, it.glyph_width,
                          it.dot_col, it.row};
            req_tuser <= it.kind;
         end
      end
   end

   // ---------------------------------------------------------------
   // response receiver: stall patterns plus one long hold-off
   // ---------------------------------------------------------------

   always @(posedge clock) begin : rsp_receiver
      int       phase_left;
      int       hold_left;
      logic     hold_done;
      logic     ready;
      rx_mode_type mode;
      if (reset) begin
         phase_left = 0;
         hold_left  = 0;
         hold_done  = 1'b0;
         mode       = RX_STEADY;
         rsp_tready <= 1'b0;
      end else begin
         // let the block fill up and push back on the request side
         if (!hold_done && items_accepted >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
         end else begin
            if (phase_left == 0) begin
               phase_left = $urandom_range(10, 60);
               mode       = rx_mode_type'($urandom_range(0, 2));
            end
            phase_left--;
            case (mode)
               RX_STEADY: ready = 1'b1;
               RX_CHOPPY: ready = ($urandom_range(0, 1) == 1);
               default:   ready = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_tready <= ready;
      end
   end

   // ---------------------------------------------------------------
   // checker: result beats first, then the request beat of the same edge
   // ---------------------------------------------------------------

   always @(posedge clock) begin : beat_checker
      row_word_type   got, want;
      glyph_item_type it;
      if (reset) begin
         wipe_line_image();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.data_word  = rsp_tdata[31:0];
            got.word_index = rsp_tdata[35:32];
            got.dot_count  = rsp_tdata[44:36];
            got.last       = rsp_tlast;
            if (expected_words.size() == 0) begin
               $display("%0t: result beat with nothing expected, data_word %h", $time,
                        got.data_word);
               mismatches++;
            end else begin
               want = expected_words.pop_front();
               if (got.data_word !== want.data_word) begin
                  $display("%0t: data_word expected %h, actual %h", $time, want.data_word,
                           got.data_word);
                  mismatches++;
               end
               if (got.word_index !== want.word_index) begin
                  $display("%0t: word_index expected %0d, actual %0d", $time,
                           want.word_index, got.word_index);
                  mismatches++;
               end
               if (got.dot_count !== want.dot_count) begin
                  $display("%0t: dot_count expected %0d, actual %0d", $time, want.dot_count,
                           got.dot_count);
                  mismatches++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last expected %b, actual %b", $time, want.last, got.last);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            it.kind          = req_tuser;
            it.row           = req_tdata[5:0];
            it.dot_col       = req_tdata[14:6];
            it.glyph_width   = req_tdata[20:15];
            it.pixels        = req_tdata[52:21];
            it.invert        = req_tdata[53];
            it.double_height = req_tdata[54];
            case (it.kind)
               KIND_BLIT:  blit_glyph_row(it);
               KIND_CLEAR: wipe_line_image();
               KIND_READ:  read_out_row(it.row);
               default: ;  // unused code, no effect
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // watchdog: too long without a beat on either channel
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL glyph_row_blit_line_store_top");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------

   initial begin
      int   n, w, st, r, pick, dbl;

      // directed: edges of every field and each corner of the placement rules
      queue_item(KIND_CLEAR, 0, 0, 1, 32'h0, 0, 0);
      queue_item(KIND_BLIT, 0, 0, 32, 32'hFFFF_FFFF, 0, 0);    // aligned, full width
      queue_item(KIND_READ, 0, 0, 1, 32'h0, 0, 0);
      queue_item(KIND_BLIT, 1, 3, 13, 32'hA5C3_F0F0, 1, 0);    // inverted, padding cleared
      queue_item(KIND_BLIT, 1, 100, 5, 32'hFFFF_FFFF, 0, 0);   // padding written as given
      queue_item(KIND_READ, 1, 0, 1, 32'h0, 0, 0);
      queue_item(KIND_BLIT, 2, 380, 4, 32'hF000_0000, 0, 0);   // spill past the line end
      queue_item(KIND_BLIT, 2, 381, 4, 32'hFFFF_FFFF, 0, 0);   // line overrun
      queue_item(KIND_BLIT, 2, 0, 0, 32'hFFFF_FFFF, 0, 0);     // zero width
      queue_item(KIND_BLIT, 2, 8, 33, 32'hFFFF_FFFF, 0, 0);    // too wide
      queue_item(KIND_BLIT, 2, 16, 63, 32'hFFFF_FFFF, 1, 1);   // too wide, all flags
      queue_item(KIND_BLIT, 2, 511, 1, 32'hFFFF_FFFF, 0, 0);   // start off the line
      queue_item(KIND_READ, 2, 0, 1, 32'h0, 0, 0);
      queue_item(KIND_BLIT, 31, 200, 24, 32'h1234_5678, 0, 1); // double height, last row pair
      queue_item(KIND_BLIT, 32, 40, 8, 32'hFFFF_FFFF, 0, 1);   // double height row overrun
      queue_item(KIND_BLIT, 63, 0, 8, 32'hFFFF_FFFF, 1, 1);    // double height row overrun
      queue_item(KIND_BLIT, 63, 352, 32, 32'hDEAD_BEEF, 1, 0); // ends on the last dot
      queue_item(KIND_READ, 62, 0, 1, 32'h0, 0, 0);
      queue_item(KIND_READ, 63, 0, 1, 32'h0, 0, 0);
      queue_item(KIND_UNUSED, 5, 77, 9, 32'h5555_AAAA, 1, 1);
      queue_item(KIND_BLIT, 40, 257, 17, 32'hC3A5_9F01, 1, 0);
      queue_item(KIND_READ, 40, 0, 1, 32'h0, 0, 0);
      queue_item(KIND_CLEAR, 63, 511, 63, 32'hFFFF_FFFF, 1, 1);
      queue_item(KIND_READ, 0, 0, 1, 32'h0, 0, 0);

      // random: mostly legal blits and reads on a few rows so the reads see content
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            w = $urandom_range(1, 32);
            if ($urandom_range(0, 2) == 0) w = 8 * $urandom_range(1, 4);
            st = $urandom_range(0, LINE_DOTS - w);
            if ($urandom_range(0, 3) == 0) st = st - st % 8;
            dbl = ($urandom_range(0, 3) == 0) ? 1 : 0;
            r   = dbl ? $urandom_range(0, 7) : $urandom_range(0, 15);
            if ($urandom_range(0, 9) == 0) r = dbl ? $urandom_range(0, 31) : $urandom_range(0, 63);
            queue_item(KIND_BLIT, r, st, w, $urandom, $urandom_range(0, 1), dbl);
         end else if (pick < 80) begin
            r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15);
            queue_item(KIND_READ, r, $urandom_range(0, 511), $urandom_range(0, 63), $urandom,
                       $urandom_range(0, 1), $urandom_range(0, 1));
         end else if (pick < 84) begin
            queue_item(KIND_CLEAR, $urandom_range(0, 63), $urandom_range(0, 511),
                       $urandom_range(0, 63), $urandom, $urandom_range(0, 1),
                       $urandom_range(0, 1));
         end else begin
            // noise: any field value, any code
            queue_item(KIND_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                       $urandom_range(0, 511), $urandom_range(0, 63), $urandom,
                       $urandom_range(0, 1), $urandom_range(0, 1));
         end
      end
      total_items = pending_items.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < total_items) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("PASS glyph_row_blit_line_store_top");
      end else begin
         $display("FAIL glyph_row_blit_line_store_top");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/grbls_pkg.sv
hdl/grbls_front.sv
hdl/grbls_fifo.sv
hdl/grbls_back.sv
hdl/glyph_row_blit_line_store_top.sv
verif/tb_glyph_row_blit_line_store_top.sv
